// ===== sv/ipmb_fp_pkg.sv =====
// shared types and constants of the ipmb frame parser
package ipmb_fp_pkg;

   localparam int unsigned MaxData = 32;
   localparam int unsigned MinLen  = 7;
   localparam int unsigned QDepth  = 4;
   localparam logic [7:0]  LunMask = 8'h03;

   typedef enum logic [2:0] {
      StOk     = 3'd0,
      StShort  = 3'd1,
      StLong   = 3'd2,
      StHdrBad = 3'd3,
      StMsgBad = 3'd4
   } status_type;

   typedef struct packed {
      logic       is_summary;
      logic [7:0] data_byte;
      logic [7:0] responder_addr;
      logic [5:0] net_function;
      logic [1:0] responder_lun;
      logic [7:0] requester_addr;
      logic [5:0] sequence_number;
      logic [1:0] requester_lun;
      logic [7:0] command_code;
      logic [5:0] payload_length;
      status_type frame_status;
      logic       last_of_run;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type first;
      rsp_item_type second;
   } push_type;

endpackage

// ===== sv/ipmb_fp_if.sv =====
// request and response channel interfaces of the ipmb frame parser
interface ipmb_fp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       end_of_message;

   modport source (output valid, output rx_byte, output end_of_message, input ready);
   modport sink (input valid, input rx_byte, input end_of_message, output ready);
endinterface

interface ipmb_fp_rsp_if;
   logic       valid;
   logic       ready;
   logic       is_summary;
   logic [7:0] data_byte;
   logic [7:0] responder_addr;
   logic [5:0] net_function;
   logic [1:0] responder_lun;
   logic [7:0] requester_addr;
   logic [5:0] sequence_number;
   logic [1:0] requester_lun;
   logic [7:0] command_code;
   logic [5:0] payload_length;
   logic [2:0] frame_status;
   logic       last_of_run;

   modport source (
      output valid, output is_summary, output data_byte, output responder_addr,
      output net_function, output responder_lun, output requester_addr,
      output sequence_number, output requester_lun, output command_code,
      output payload_length, output frame_status, output last_of_run,
      input ready
   );
   modport sink (
      input valid, input is_summary, input data_byte, input responder_addr,
      input net_function, input responder_lun, input requester_addr,
      input sequence_number, input requester_lun, input command_code,
      input payload_length, input frame_status, input last_of_run,
      output ready
   );
endinterface

// ===== sv/ipmb_fp_parser.sv =====
// byte counter, running checksums, header capture and result generation
module ipmb_fp_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_accept,
   input  logic [7:0]            in_byte,
   input  logic                  in_last,
   output ipmb_fp_pkg::push_type push_o
);
   import ipmb_fp_pkg::*;

   localparam logic [8:0] MaxData9 = 9'(MaxData);
   localparam logic [7:0] MinLen8  = 8'(MinLen);

   logic [7:0]      pos_ff, pos_in;
   logic [7:0]      hsum_ff, hsum_in;
   logic [7:0]      msum_ff, msum_in;
   logic [7:0]      held_ff, held_in;
   logic [4:0][7:0] hdr_ff, hdr_in;
   logic            over_ff, over_in;

   logic [4:0][7:0] hdr_cap;
   logic            over_cap;
   logic            data_zone;
   logic            data_ok;
   logic [8:0]      plen_raw;
   logic [8:0]      plen_cap;
   rsp_item_type    data_item;
   rsp_item_type    sum_item;
   status_type      status;

   always_comb begin
      hdr_cap   = hdr_ff;
      unique case (pos_ff)
         8'd0: hdr_cap[0] = in_byte;
         8'd1: hdr_cap[1] = in_byte;
         8'd3: hdr_cap[2] = in_byte;
         8'd4: hdr_cap[3] = in_byte;
         8'd5: hdr_cap[4] = in_byte;
         default: ;
      endcase

      data_zone = pos_ff >= MinLen8;
      data_ok   = data_zone && (({1'b0, pos_ff} - 9'(MinLen)) < MaxData9);
      over_cap  = over_ff | (data_zone & ~data_ok);

      plen_raw = {1'b0, pos_ff} - 9'(MinLen - 1);
      plen_cap = (plen_raw > MaxData9) ? MaxData9 : plen_raw;

      msum_in = msum_ff + in_byte;
      hsum_in = (pos_ff < 8'd3) ? hsum_ff + in_byte : hsum_ff;

      // short first, then too long, header sum, message sum
      priority if (pos_ff < MinLen8 - 8'd1) begin
         status = StShort;
      end else if (over_cap) begin
         status = StLong;
      end else if (hsum_in != 8'd0) begin
         status = StHdrBad;
      end else if (msum_in != 8'd0) begin
         status = StMsgBad;
      end else begin
         status = StOk;
      end

      data_item             = '0;
      data_item.data_byte   = held_ff;
      data_item.last_of_run = ~in_last;

      sum_item                 = '0;
      sum_item.is_summary      = 1'b1;
      sum_item.responder_addr  = hdr_cap[0];
      sum_item.net_function    = hdr_cap[1][7:2];
      sum_item.responder_lun   = 2'(hdr_cap[1] & LunMask);
      sum_item.requester_addr  = hdr_cap[2];
      sum_item.sequence_number = hdr_cap[3][7:2];
      sum_item.requester_lun   = 2'(hdr_cap[3] & LunMask);
      sum_item.command_code    = hdr_cap[4];
      sum_item.payload_length  = (status == StShort) ? 6'd0 : plen_cap[5:0];
      sum_item.frame_status    = status;
      sum_item.last_of_run     = 1'b1;

      push_o = '0;
      if (in_accept) begin
         unique case ({data_ok, in_last})
            2'b10: begin
               push_o.count = 2'd1;
               push_o.first = data_item;
            end
            2'b01: begin
               push_o.count = 2'd1;
               push_o.first = sum_item;
            end
            2'b11: begin
               push_o.count  = 2'd2;
               push_o.first  = data_item;
               push_o.second = sum_item;
            end
            default: push_o.count = 2'd0;
         endcase
      end

      held_in = in_byte;
      hdr_in  = hdr_cap;
      over_in = over_cap;
      pos_in  = (pos_ff == 8'hff) ? pos_ff : pos_ff + 8'd1;
      if (in_last) begin
         pos_in  = '0;
         hsum_in = '0;
         msum_in = '0;
         held_in = '0;
         hdr_in  = '0;
         over_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         hsum_ff <= '0;
         msum_ff <= '0;
         held_ff <= '0;
         hdr_ff  <= '0;
         over_ff <= 1'b0;
      end else if (in_accept) begin
         pos_ff  <= pos_in;
         hsum_ff <= hsum_in;
         msum_ff <= msum_in;
         held_ff <= held_in;
         hdr_ff  <= hdr_in;
         over_ff <= over_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (push_o.count == 2'd2) |-> (push_o.second.is_summary && !push_o.first.is_summary))
      else $error("two results without data then summary order");

   assert property (@(posedge clock) disable iff (reset)
      (in_accept && in_last) |=> (pos_ff == 8'd0 && over_ff == 1'b0))
      else $error("state not cleared after end of message");

   assert property (@(posedge clock) disable iff (reset)
      (push_o.count != 2'd0) |-> in_accept)
      else $error("result pushed without an accepted beat");

endmodule

// ===== sv/ipmb_fp_queue.sv =====
// small result queue taking up to two results per beat
module ipmb_fp_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  ipmb_fp_pkg::push_type     push_i,
   output logic                      space_o,
   output logic                      out_valid,
   input  logic                      out_ready,
   output ipmb_fp_pkg::rsp_item_type out_item
);
   import ipmb_fp_pkg::*;

   localparam int unsigned PtrW = $clog2(QDepth);
   localparam logic [PtrW:0] DepthC = (PtrW + 1)'(QDepth);

   rsp_item_type    mem [QDepth];
   logic [PtrW-1:0] wr_ff, wr_in;
   logic [PtrW-1:0] rd_ff, rd_in;
   logic [PtrW:0]   cnt_ff, cnt_in;
   logic            pop;

   always_comb begin
      pop       = out_valid & out_ready;
      wr_in     = wr_ff + PtrW'(push_i.count);
      rd_in     = rd_ff + PtrW'(pop);
      cnt_in    = cnt_ff + (PtrW + 1)'(push_i.count) - (PtrW + 1)'(pop);
      out_valid = cnt_ff != '0;
      out_item  = mem[rd_ff];
      space_o   = cnt_ff <= DepthC - (PtrW + 1)'(2);
   end

   always_ff @(posedge clock) begin
      if (push_i.count != 2'd0) begin
         mem[wr_ff] <= push_i.first;
      end
      if (push_i.count == 2'd2) begin
         mem[wr_ff + PtrW'(1)] <= push_i.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff <= DepthC)
      else $error("result queue over depth");

   assert property (@(posedge clock) disable iff (reset)
      (PtrW + 1)'(push_i.count) <= DepthC - cnt_ff)
      else $error("push overruns result queue");

   assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_ready) |=> (out_valid && out_item == $past(out_item)))
      else $error("stalled result changed");

endmodule

// ===== sv/ipmb_frame_parser_core.sv =====
// top level of the ipmb frame parser
// a data byte is pushed into the result queue when the byte that follows it is accepted
// the summary is pushed into the result queue when the final byte is accepted, behind a data byte when one goes first
// throughput: one byte per cycle while the result queue has space, set by the running sums and the result queue
// the result queue takes a beat while it holds at most two results
// reset clears the counter, sums, captured header and the result queue at once
module ipmb_frame_parser_core (
   input  logic          clock,
   input  logic          reset,
   ipmb_fp_req_if.sink   req_if,
   ipmb_fp_rsp_if.source rsp_if
);
   import ipmb_fp_pkg::*;

   push_type     push;
   rsp_item_type item;
   logic         space;
   logic         accept;

   assign req_if.ready = space;
   assign accept       = req_if.valid & space;

   ipmb_fp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .in_accept (accept),
      .in_byte   (req_if.rx_byte),
      .in_last   (req_if.end_of_message),
      .push_o    (push)
   );

   ipmb_fp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_i    (push),
      .space_o   (space),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .out_item  (item)
   );

   assign rsp_if.is_summary      = item.is_summary;
   assign rsp_if.data_byte       = item.data_byte;
   assign rsp_if.responder_addr  = item.responder_addr;
   assign rsp_if.net_function    = item.net_function;
   assign rsp_if.responder_lun   = item.responder_lun;
   assign rsp_if.requester_addr  = item.requester_addr;
   assign rsp_if.sequence_number = item.sequence_number;
   assign rsp_if.requester_lun   = item.requester_lun;
   assign rsp_if.command_code    = item.command_code;
   assign rsp_if.payload_length  = item.payload_length;
   assign rsp_if.frame_status    = item.frame_status;
   assign rsp_if.last_of_run     = item.last_of_run;

endmodule

// ===== verif/ipmb_fp_checker.sv =====
`timescale 1ns / 100ps
// scoreboard of the ipmb frame parser: predicts each response beat and compares it field by field
module ipmb_fp_checker (
   input  logic        clock,
   input  logic        reset,
   ipmb_fp_req_if      req_mon,
   ipmb_fp_rsp_if      rsp_mon,
   output int unsigned fail_count,
   output int unsigned results_due
);
   import ipmb_fp_pkg::*;

   logic [7:0]   byte_index;
   logic [7:0]   hdr_sum;
   logic [7:0]   msg_sum;
   logic [7:0]   prev_byte;
   logic [7:0]   rs_addr;
   logic [7:0]   netfn_lun;
   logic [7:0]   rq_addr;
   logic [7:0]   seq_lun;
   logic [7:0]   cmd_byte;
   logic         data_dropped;
   rsp_item_type results_ahead[$];
   int unsigned  mismatches = 0;
   int unsigned  due_count = 0;

   assign fail_count  = mismatches;
   assign results_due = due_count;

   task automatic clear_frame();
      byte_index   = '0;
      hdr_sum      = '0;
      msg_sum      = '0;
      prev_byte    = '0;
      rs_addr      = '0;
      netfn_lun    = '0;
      rq_addr      = '0;
      seq_lun      = '0;
      cmd_byte     = '0;
      data_dropped = 1'b0;
   endtask

   task automatic report(input string what);
      if (mismatches < 50) begin
         $display("%0t ipmb_fp_checker: %s", $time, what);
      end
      mismatches++;
   endtask

   task automatic check_field(input string name, input int unsigned got, input int unsigned want);
      if (got != want) begin
         report($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
      end
   endtask

   task automatic deframe_byte(input logic [7:0] rx, input logic eom);
      int unsigned  p;
      int unsigned  plen;
      rsp_item_type r;
      p = byte_index;
      msg_sum = msg_sum + rx;
      if (p < 3) begin
         hdr_sum = hdr_sum + rx;
      end
      case (p)
         0: rs_addr = rx;
         1: netfn_lun = rx;
         3: rq_addr = rx;
         4: seq_lun = rx;
         5: cmd_byte = rx;
         default: ;
      endcase
      // the held byte is payload once a later byte shows it was not the checksum
      if (p >= MinLen) begin
         if (p - MinLen < MaxData) begin
            r = '0;
            r.data_byte   = prev_byte;
            r.last_of_run = !eom;
            results_ahead.push_back(r);
         end else begin
            data_dropped = 1'b1;
         end
      end
      prev_byte = rx;
      if (!eom) begin
         if (p < 255) begin
            byte_index = byte_index + 8'd1;
         end
      end else begin
         r = '0;
         r.is_summary      = 1'b1;
         r.responder_addr  = rs_addr;
         r.net_function    = netfn_lun[7:2];
         r.responder_lun   = 2'(netfn_lun & LunMask);
         r.requester_addr  = rq_addr;
         r.sequence_number = seq_lun[7:2];
         r.requester_lun   = 2'(seq_lun & LunMask);
         r.command_code    = cmd_byte;
         r.last_of_run     = 1'b1;
         if (p + 1 < MinLen) begin
            plen = 0;
            r.frame_status = StShort;
         end else begin
            plen = p - (MinLen - 1);
            if (plen > MaxData) begin
               plen = MaxData;
            end
            if (data_dropped) begin
               r.frame_status = StLong;
            end else if (hdr_sum != 0) begin
               r.frame_status = StHdrBad;
            end else if (msg_sum != 0) begin
               r.frame_status = StMsgBad;
            end else begin
               r.frame_status = StOk;
            end
         end
         r.payload_length = 6'(plen);
         results_ahead.push_back(r);
         clear_frame();
      end
   endtask

   task automatic compare_beat(input rsp_item_type want);
      check_field("is_summary", rsp_mon.is_summary, want.is_summary);
      check_field("data_byte", rsp_mon.data_byte, want.data_byte);
      check_field("responder_addr", rsp_mon.responder_addr, want.responder_addr);
      check_field("net_function", rsp_mon.net_function, want.net_function);
      check_field("responder_lun", rsp_mon.responder_lun, want.responder_lun);
      check_field("requester_addr", rsp_mon.requester_addr, want.requester_addr);
      check_field("sequence_number", rsp_mon.sequence_number, want.sequence_number);
      check_field("requester_lun", rsp_mon.requester_lun, want.requester_lun);
      check_field("command_code", rsp_mon.command_code, want.command_code);
      check_field("payload_length", rsp_mon.payload_length, want.payload_length);
      check_field("frame_status", rsp_mon.frame_status, int'(want.frame_status));
      check_field("last_of_run", rsp_mon.last_of_run, want.last_of_run);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_frame();
         results_ahead.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            deframe_byte(req_mon.rx_byte, req_mon.end_of_message);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (results_ahead.size() == 0) begin
               report("response beat with nothing expected");
            end else begin
               compare_beat(results_ahead.pop_front());
            end
         end
      end
      due_count <= results_ahead.size();
   end

endmodule

// ===== verif/tb_ipmb_frame_parser_core.sv =====
`timescale 1ns / 100ps
// testbench top of the ipmb frame parser: clock, reset, frame stimulus, watchdog and verdict
module tb_ipmb_frame_parser_core;
   import ipmb_fp_pkg::*;

   localparam int unsigned StallLimit  = 5000;
   localparam int unsigned StimBytes   = 1100;
   localparam int unsigned LongHold    = 300;
   localparam int unsigned DrainCycles = 20;
   localparam int unsigned GiantData   = 253;

   typedef enum int {
      FlawNone,
      FlawHdrSum,
      FlawMsgSum,
      FlawBothSums
   } flaw_type;

   logic        clock;
   logic        reset;
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned hold_left;
   int unsigned bytes_sent;
   int unsigned idle_cycles = 0;
   int unsigned fail_count;
   int unsigned results_due;
   logic [7:0]  frame_buf[$];

   ipmb_fp_req_if req_if ();
   ipmb_fp_rsp_if rsp_if ();

   ipmb_frame_parser_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   ipmb_fp_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_if),
      .rsp_mon     (rsp_if),
      .fail_count  (fail_count),
      .results_due (results_due)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // receiver: random back-pressure, or a long hold-off when one is requested
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_if.ready = 1'b0;
            hold_left--;
         end else begin
            rsp_if.ready = ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
         $display("tb_ipmb_frame_parser_core: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_frame();
      for (int i = 0; i < frame_buf.size(); i++) begin
         while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid = 1'b0;
            @(negedge clock);
         end
         req_if.valid          = 1'b1;
         req_if.rx_byte        = frame_buf[i];
         req_if.end_of_message = (i == frame_buf.size() - 1);
         do @(posedge clock); while (!req_if.ready);
         @(negedge clock);
         bytes_sent++;
      end
   endtask

   task automatic build_frame(input int unsigned n_data, input flaw_type flaw);
      logic [7:0] tail_sum;
      int unsigned last;
      frame_buf.delete();
      frame_buf.push_back(8'($urandom));
      frame_buf.push_back(8'($urandom));
      frame_buf.push_back(8'd0 - frame_buf[0] - frame_buf[1]);
      tail_sum = '0;
      repeat (3 + n_data) begin
         frame_buf.push_back(8'($urandom));
         tail_sum = tail_sum + frame_buf[frame_buf.size() - 1];
      end
      frame_buf.push_back(8'd0 - tail_sum);
      last = frame_buf.size() - 1;
      if (flaw == FlawHdrSum || flaw == FlawBothSums) begin
         frame_buf[2] = frame_buf[2] ^ 8'($urandom_range(255, 1));
      end
      if (flaw == FlawMsgSum || flaw == FlawBothSums) begin
         frame_buf[last] = frame_buf[last] ^ 8'($urandom_range(255, 1));
      end
   endtask

   task automatic build_noise(input int unsigned n_bytes);
      frame_buf.delete();
      repeat (n_bytes) frame_buf.push_back(8'($urandom));
   endtask

   task automatic random_frame();
      int unsigned pick;
      int unsigned n_data;
      pick = $urandom_range(99);
      n_data = ($urandom_range(3) == 0) ? $urandom_range(MaxData) : $urandom_range(6);
      if (pick < 60) begin
         build_frame(n_data, FlawNone);
      end else if (pick < 70) begin
         build_frame(n_data, FlawHdrSum);
      end else if (pick < 78) begin
         build_frame(n_data, FlawMsgSum);
      end else if (pick < 82) begin
         build_frame(n_data, FlawBothSums);
      end else if (pick < 88) begin
         build_frame($urandom_range(MaxData + 8, MaxData + 1), flaw_type'(int'($urandom_range(3))));
      end else if (pick < 94) begin
         build_noise($urandom_range(MinLen - 1, 1));
      end else begin
         build_noise($urandom_range(20, 1));
      end
      send_frame();
   endtask

   initial begin
      reset                 = 1'b1;
      req_if.valid          = 1'b0;
      req_if.rx_byte        = '0;
      req_if.end_of_message = 1'b0;
      send_idle_pct         = 32;
      recv_idle_pct         = 73;
      hold_left             = 0;
      bytes_sent            = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // one-byte frame, then the longest short frame
      frame_buf = '{8'hFF};
      send_frame();
      frame_buf = '{8'h00, 8'hFF, 8'h01, 8'hFF, 8'h00, 8'hFF};
      send_frame();
      // clean frame with two payload bytes at the extremes
      frame_buf = '{8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h04};
      send_frame();
      // bad header sum, then bad message sum with a good header
      frame_buf = '{8'h20, 8'h18, 8'h00, 8'h81, 8'h04, 8'h01, 8'h7A};
      send_frame();
      frame_buf = '{8'h20, 8'h18, 8'hC8, 8'h81, 8'h04, 8'h01, 8'h00};
      send_frame();

      while (bytes_sent < StimBytes * 2 / 5) random_frame();

      send_idle_pct = 73;
      recv_idle_pct = 32;
      // long receiver stall under an overlong frame that saturates the byte counter
      hold_left = LongHold;
      build_frame(GiantData, FlawNone);
      send_frame();
      while (bytes_sent < StimBytes * 7 / 10) random_frame();

      req_if.valid = 1'b0;
      wait (results_due == 0);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      while (bytes_sent < StimBytes) random_frame();

      req_if.valid = 1'b0;
      wait (results_due == 0);
      repeat (DrainCycles) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_ipmb_frame_parser_core: done, clean");
      end else begin
         $display("tb_ipmb_frame_parser_core: done, errors");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/ipmb_fp_pkg.sv
sv/ipmb_fp_if.sv
sv/ipmb_fp_parser.sv
sv/ipmb_fp_queue.sv
sv/ipmb_frame_parser_core.sv
verif/ipmb_fp_checker.sv
verif/tb_ipmb_frame_parser_core.sv
